@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HVA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hva assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define HVA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hva assertion failed");

`endif

@@ rtl/hva_pkg.sv @@
// ---------------------------------------------------------------------------
// hva_pkg
// Types, codes and elaboration-time tables of the Hough line vote accumulator.
// ---------------------------------------------------------------------------
package hva_pkg;

	localparam int NUM_ANGLES = 256;
	localparam int NUM_RADII  = 256;
	localparam int ANG_W      = 8;
	localparam int RAD_IDX_W  = 8;
	localparam int ADDR_W     = ANG_W + RAD_IDX_W;
	localparam int STORE_DEPTH = NUM_ANGLES * NUM_RADII;
	localparam int TRIG_W     = 16;
	localparam int DELTA_W    = 12;
	localparam int RADSUM_W   = 29;
	localparam int BPROD_W    = 52;
	localparam int WEIGHT_W   = 17;

	localparam logic [1:0] OP_VOTE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_MAX    = 3'd2;
	localparam logic [2:0] REG_BAND   = 3'd3;
	localparam logic [2:0] REG_SCALE  = 3'd4;

	localparam logic [WEIGHT_W-1:0] BASE_FULL = WEIGHT_W'(512);
	localparam logic [WEIGHT_W-1:0] BASE_BAND = WEIGHT_W'(640);

	typedef struct packed {
		logic [1:0] operation;
		logic [9:0] pixel_row;
		logic [9:0] pixel_col;
		logic [7:0] pixel_value;
		logic [7:0] read_angle;
		logic [7:0] read_radius;
	} in_t;

	typedef struct packed {
		logic [31:0] cell_votes;
		logic [7:0]  cell_angle;
		logic [7:0]  cell_radius;
	} out_t;

	// vote request leaving the angle sweep chain
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
	} hit_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_DRAIN,
		ST_READ,
		ST_RDATA
	} state_t;

	function automatic longint unsigned qmul(input longint unsigned a,
		input longint unsigned b);
		return (a * b) >> 30;
	endfunction

	// Q1.14 sine (want_cos = 0) or cosine (want_cos = 1) of angle index a
	function automatic logic signed [TRIG_W-1:0] trig_val(input int a, input bit want_cos);
		longint unsigned m, x, x2, x3, x4, x5, x6, x7, x8, s, c;
		int oct, rem, u, k, sp, cp, skv, ckv, sn, cs;
		m   = longint'(a) * 8;
		oct = int'((m / NUM_ANGLES) % 8);
		rem = int'(m % NUM_ANGLES);
		u   = (oct % 2 == 1) ? NUM_ANGLES - rem : rem;
		x   = (64'd843314856 * longint'(u)) / NUM_ANGLES;
		x2  = qmul(x, x);
		x3  = qmul(x2, x);
		x4  = qmul(x2, x2);
		x5  = qmul(x4, x);
		x6  = qmul(x4, x2);
		x7  = qmul(x6, x);
		x8  = qmul(x4, x4);
		s   = x + x5 / 120 - x3 / 6 - x7 / 5040;
		c   = 64'd1073741824 + x4 / 24 + x8 / 40320 - x2 / 2 - x6 / 720;
		sp  = int'((s + 32768) >> 16);
		cp  = int'((c + 32768) >> 16);
		if (oct % 2 == 0) begin
			k = (oct / 2) % 4;
		end else begin
			k = ((oct + 1) / 2) % 4;
		end
		skv = (k == 1) ? 1 : ((k == 3) ? -1 : 0);
		ckv = (k == 0) ? 1 : ((k == 2) ? -1 : 0);
		if (oct % 2 == 0) begin
			sn = skv * cp + ckv * sp;
			cs = ckv * cp - skv * sp;
		end else begin
			sn = skv * cp - ckv * sp;
			cs = ckv * cp + skv * sp;
		end
		return want_cos ? TRIG_W'(cs) : TRIG_W'(sn);
	endfunction

	// angle within 7.5 degrees of 0, pi or 2*pi
	function automatic logic in_band(input int a);
		longint t, c, d;
		logic hit;
		hit = 1'b0;
		t = longint'(a) * 720;
		for (int k = 0; k < 3; k++) begin
			c = longint'(360) * k * NUM_ANGLES;
			d = (t >= c) ? t - c : c - t;
			if (d <= longint'(NUM_ANGLES) * 15)
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

@@ rtl/hva_ram.sv @@
// ---------------------------------------------------------------------------
// hva_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module hva_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/hva_div.sv @@
// ---------------------------------------------------------------------------
// hva_div
// Restoring divider, one quotient bit a cycle: (value * 256) / image_max.
// ---------------------------------------------------------------------------
module hva_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [15:0] quotient
);

	logic [15:0] shf_q;
	logic [7:0]  rem_q;
	logic [7:0]  dvs_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [8:0]  trial;
	logic        fits;

	// trial subtract of the next dividend bit
	assign trial = {rem_q, shf_q[15]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shf_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
			shf_q <= {shf_q[14:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = shf_q;

endmodule

@@ rtl/hva_sweep_chain.sv @@
// ---------------------------------------------------------------------------
// hva_sweep_chain
// Chain of stage cells turning one angle a cycle into a vote cell address.
// ---------------------------------------------------------------------------
module hva_sweep_chain (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                feed,
	input  logic [hva_pkg::ANG_W-1:0]           angle,
	input  logic                                band_mode,
	input  logic signed [hva_pkg::DELTA_W-1:0]  dr,
	input  logic signed [hva_pkg::DELTA_W-1:0]  dc,
	input  logic [23:0]                         radius_scale,
	output hva_pkg::hit_t                       hit
);

	logic signed [hva_pkg::TRIG_W-1:0] sin_tab [hva_pkg::NUM_ANGLES];
	logic signed [hva_pkg::TRIG_W-1:0] cos_tab [hva_pkg::NUM_ANGLES];
	logic [hva_pkg::NUM_ANGLES-1:0]    band_tab;

	// constant tables, built at elaboration
	for (genvar g = 0; g < hva_pkg::NUM_ANGLES; g++) begin : g_tab
		assign sin_tab[g]  = hva_pkg::trig_val(g, 1'b0);
		assign cos_tab[g]  = hva_pkg::trig_val(g, 1'b1);
		assign band_tab[g] = hva_pkg::in_band(g);
	end

	logic                              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [hva_pkg::ANG_W-1:0]         ang_s1, ang_s2, ang_s3, ang_s4;
	logic signed [hva_pkg::TRIG_W-1:0] sn_s1, cs_s1;
	logic signed [hva_pkg::RADSUM_W-2:0] ps_s2, pc_s2;
	logic signed [hva_pkg::RADSUM_W-1:0] rad_s3;
	logic [hva_pkg::BPROD_W-1:0]       prod_s4;
	logic [hva_pkg::ADDR_W-1:0]        addr_s5;

	// valid bits of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= feed && (!band_mode || band_tab[angle]);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && !rad_s3[hva_pkg::RADSUM_W-1];
			v_s5 <= v_s4 && (prod_s4[hva_pkg::BPROD_W-1:38] == '0);
		end
	end

	// payload: table look-up, products, radius sum, bucket product, address
	always_ff @(posedge clk) begin
		ang_s1  <= angle;
		sn_s1   <= sin_tab[angle];
		cs_s1   <= cos_tab[angle];
		ang_s2  <= ang_s1;
		ps_s2   <= (hva_pkg::RADSUM_W-1)'(sn_s1 * dr);
		pc_s2   <= (hva_pkg::RADSUM_W-1)'(cs_s1 * dc);
		ang_s3  <= ang_s2;
		rad_s3  <= hva_pkg::RADSUM_W'(ps_s2) + hva_pkg::RADSUM_W'(pc_s2);
		ang_s4  <= ang_s3;
		prod_s4 <= hva_pkg::BPROD_W'(rad_s3[hva_pkg::RADSUM_W-2:0]) *
			hva_pkg::BPROD_W'(radius_scale);
		addr_s5 <= {ang_s4, prod_s4[37:30]};
	end

	assign hit.valid = v_s5;
	assign hit.addr  = addr_s5;

endmodule

@@ rtl/hough_line_vote_accumulator_core.sv @@
// ---------------------------------------------------------------------------
// hough_line_vote_accumulator_core
// Hough line accumulator: 256 angles by 256 radius buckets of Q24.8 votes.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries vote, read and clear
// transactions; output channel out_valid/out_ready/out_data returns one cell
// for each read. Items are worked one at a time.
// A vote whose value passes the threshold goes through the weight divider,
// a sweep over all 256 angles (at most one read-modify-write of the vote
// RAM per angle) and a drain of the sweep chain. A vote below the threshold
// and an unknown operation leave the block idle, ready for the next item.
// A read waits in ST_READ until the output register is free or being taken,
// then ST_RDATA loads the registered RAM data into it; a stalled receiver
// holds the result, and the next read waits in the block until it is taken.
// Reset and a clear transaction zero the store with a pass over all 65536
// cells, one cell a cycle, during which in_ready is low. Configuration writes
// over the APB port are taken at any time.
// ---------------------------------------------------------------------------
module hough_line_vote_accumulator_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hva_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output hva_pkg::out_t out_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	hva_pkg::state_t state_q, state_d;

	logic [10:0] width_q, height_q;
	logic [7:0]  max_q;
	logic        band_q;
	logic [23:0] scale_q;

	logic [hva_pkg::ADDR_W-1:0]   clr_cnt_q;
	logic [hva_pkg::ANG_W-1:0]    ang_q;
	logic [2:0]                   drain_q;
	logic [9:0]                   row_q, col_q;
	logic [7:0]                   rd_ang_q, rd_rad_q;
	logic [hva_pkg::WEIGHT_W-1:0] weight_q;
	logic                         out_valid_q;
	hva_pkg::out_t                out_q;

	logic        in_fire, cfg_wr;
	logic [7:0]  mx;
	logic        passes;
	logic        div_start, div_done;
	logic [15:0] div_quo;
	logic signed [hva_pkg::DELTA_W-1:0] dr, dc;
	hva_pkg::hit_t hit;

	logic                         wb_valid_s6;
	logic [hva_pkg::ADDR_W-1:0]   wb_addr_s6;
	logic [hva_pkg::ADDR_W-1:0]   raddr, waddr;
	logic [31:0]                  rdata, wdata;
	logic                         we;
	logic [32:0]                  sum;

	localparam logic [2:0] DRAIN_LAST = 3'd5;

	assign in_fire = in_valid && in_ready;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 11'd1024;
			max_q    <= 8'd255;
			band_q   <= 1'b0;
			scale_q  <= 24'd23082;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				hva_pkg::REG_WIDTH:  width_q  <= pwdata[10:0];
				hva_pkg::REG_HEIGHT: height_q <= pwdata[10:0];
				hva_pkg::REG_MAX:    max_q    <= pwdata[7:0];
				hva_pkg::REG_BAND:   band_q   <= pwdata[0];
				hva_pkg::REG_SCALE:  scale_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (paddr[4:2])
			hva_pkg::REG_WIDTH:  prdata = {21'd0, width_q};
			hva_pkg::REG_HEIGHT: prdata = {21'd0, height_q};
			hva_pkg::REG_MAX:    prdata = {24'd0, max_q};
			hva_pkg::REG_BAND:   prdata = {31'd0, band_q};
			hva_pkg::REG_SCALE:  prdata = {8'd0, scale_q};
			default:             prdata = '0;
		endcase
	end

	// threshold: 20 * value above image_max (zero max counts as one)
	assign mx     = (max_q == 8'd0) ? 8'd1 : max_q;
	assign passes = ({in_data.pixel_value, 4'd0} + {2'd0, in_data.pixel_value, 2'd0}) >
		{5'd0, mx};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hva_pkg::ST_CLEAR: if (&clr_cnt_q) state_d = hva_pkg::ST_IDLE;
			hva_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (in_data.operation)
						hva_pkg::OP_VOTE:  if (passes) state_d = hva_pkg::ST_DIV;
						hva_pkg::OP_READ:  state_d = hva_pkg::ST_READ;
						hva_pkg::OP_CLEAR: state_d = hva_pkg::ST_CLEAR;
						default: ;
					endcase
				end
			end
			hva_pkg::ST_DIV:   if (div_done) state_d = hva_pkg::ST_WALK;
			hva_pkg::ST_WALK:  if (&ang_q) state_d = hva_pkg::ST_DRAIN;
			hva_pkg::ST_DRAIN: if (drain_q == DRAIN_LAST) state_d = hva_pkg::ST_IDLE;
			hva_pkg::ST_READ:  if (!out_valid_q || out_ready) state_d = hva_pkg::ST_RDATA;
			hva_pkg::ST_RDATA: state_d = hva_pkg::ST_IDLE;
			default:           state_d = hva_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = (state_q == hva_pkg::ST_IDLE);
		div_start = (state_q == hva_pkg::ST_IDLE) && in_fire &&
			(in_data.operation == hva_pkg::OP_VOTE) && passes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hva_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			ang_q       <= '0;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
			wb_valid_s6 <= 1'b0;
		end else begin
			state_q     <= state_d;
			wb_valid_s6 <= hit.valid;
			if (state_q == hva_pkg::ST_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == hva_pkg::ST_WALK)
				ang_q <= ang_q + 1'b1;
			else
				ang_q <= '0;
			if (state_q == hva_pkg::ST_DRAIN)
				drain_q <= drain_q + 3'd1;
			else
				drain_q <= '0;
			if (state_q == hva_pkg::ST_RDATA)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// item fields, weight, write-back address and output register
	always_ff @(posedge clk) begin
		wb_addr_s6 <= hit.addr;
		if (in_fire) begin
			row_q    <= in_data.pixel_row;
			col_q    <= in_data.pixel_col;
			rd_ang_q <= in_data.read_angle;
			rd_rad_q <= in_data.read_radius;
		end
		if (div_done)
			weight_q <= hva_pkg::WEIGHT_W'(div_quo) +
				(band_q ? hva_pkg::BASE_BAND : hva_pkg::BASE_FULL);
		if (state_q == hva_pkg::ST_RDATA) begin
			out_q.cell_votes  <= rdata;
			out_q.cell_angle  <= rd_ang_q;
			out_q.cell_radius <= rd_rad_q;
		end
	end

	hva_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({in_data.pixel_value, 8'd0}),
		.divisor  (mx),
		.done     (div_done),
		.quotient (div_quo)
	);

	// pixel offsets from the image centre
	assign dr = $signed({2'd0, row_q}) - $signed({2'd0, height_q[10:1]});
	assign dc = $signed({2'd0, col_q}) - $signed({2'd0, width_q[10:1]});

	hva_sweep_chain u_chain (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed         (state_q == hva_pkg::ST_WALK),
		.angle        (ang_q),
		.band_mode    (band_q),
		.dr           (dr),
		.dc           (dc),
		.radius_scale (scale_q),
		.hit          (hit)
	);

	// saturating write-back, or zero during the clearing pass
	assign sum   = {1'b0, rdata} + 33'(weight_q);
	assign raddr = (state_q == hva_pkg::ST_READ) ? {rd_ang_q, rd_rad_q} : hit.addr;
	assign we    = (state_q == hva_pkg::ST_CLEAR) || wb_valid_s6;
	assign waddr = (state_q == hva_pkg::ST_CLEAR) ? clr_cnt_q : wb_addr_s6;
	assign wdata = (state_q == hva_pkg::ST_CLEAR) ? 32'd0 :
		(sum[32] ? 32'hFFFF_FFFF : sum[31:0]);

	hva_ram #(
		.WIDTH (32),
		.DEPTH (hva_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/hva_checker.sv @@
// ---------------------------------------------------------------------------
// hva_checker
// Port-level checks of the accumulator core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hva_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input hva_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input hva_pkg::out_t out_data
);

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	// a stalled result holds
	`HVA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// a clear starts the clearing pass, so nothing more is taken next cycle
	`HVA_ASSERT_NEXT(a_clear_busy, in_fire && in_data.operation == hva_pkg::OP_CLEAR,
		!in_ready)

	// a read leaves the block busy for its look-up
	`HVA_ASSERT_NEXT(a_read_busy, in_fire && in_data.operation == hva_pkg::OP_READ,
		!in_ready && !$rose(out_valid))

	// a new result never shows while items are being taken
	`HVA_ASSERT_NOW(a_result_source, $rose(out_valid), !$past(in_ready))

endmodule

bind hough_line_vote_accumulator_core hva_checker u_hva_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
